// ===== hdl/wtslf_pkg.sv =====
// Package for the windowed three-stage level filter.
// Holds shared widths, register codes and the queue entry type.
// No dependencies.
package wtslf_pkg;

  localparam int BucketDepth = 4096;
  localparam int SlotW = $clog2(BucketDepth);
  localparam int CountW = 13;
  localparam int StampW = 24;
  localparam int LevelW = 6;
  localparam int EntryW = StampW + LevelW;
  localparam int AddrW = 5;

  typedef enum logic [2:0] {
    REG_BUCKET_COUNT = 3'd0,
    REG_CAP_LEVEL    = 3'd1,
    REG_EXPIRE_GAP   = 3'd2,
    REG_SEED_ONE     = 3'd3,
    REG_SEED_TWO     = 3'd4,
    REG_SEED_THREE   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [31:0]       key;
    logic [StampW-1:0] stamp;
    logic [SlotW-1:0]  slot1;
    logic [SlotW-1:0]  slot2;
    logic [SlotW-1:0]  slot3;
    logic [LevelW-1:0] lvl1;
    logic [LevelW-1:0] lvl2;
    logic [LevelW-1:0] lvl3;
  } work_t;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [LevelW-1:0] cap;
    logic [7:0]        gap;
    logic [31:0]       seed1;
    logic [31:0]       seed2;
    logic [31:0]       seed3;
  } cfg_t;

endpackage

// ===== hdl/wtslf_front.sv =====
// Front end: hashes the key for each stage, reduces modulo bucket count,
// and computes the level of each random word. Depends on wtslf_pkg.
module wtslf_front import wtslf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       key,
  input  logic [StampW-1:0] stamp,
  input  logic [31:0]       r1,
  input  logic [31:0]       r2,
  input  logic [31:0]       r3,
  output logic              out_valid,
  input  logic              out_stall,
  output work_t             out_item
);

  typedef enum logic [2:0] {S_IDLE, S_MIX, S_FIN1, S_FIN2, S_MOD, S_DONE} state_t;

  state_t            state;
  logic [1:0]        lane;
  logic [31:0]       key_r;
  logic [StampW-1:0] stamp_r;
  logic [LevelW-1:0] lvl [3];
  logic [31:0]       h;
  logic [31:0]       k;
  logic [31:0]       rem;
  logic [5:0]        bitn;
  logic [CountW-1:0] cnt;
  logic [SlotW-1:0]  slot_q [3];

  function automatic logic [LevelW-1:0] level_of(input logic [31:0] w);
    logic [LevelW-1:0] r;
    r = LevelW'(33);
    for (int i = 1; i < 31; i++) begin
      if (w[i]) r = LevelW'(33 - i);
    end
    if (w[31]) r = LevelW'(33);
    return r;
  endfunction

  logic [31:0] seed_sel;
  always_comb begin
    unique case (lane)
      2'd0:    seed_sel = cfg.seed1;
      2'd1:    seed_sel = cfg.seed2;
      default: seed_sel = cfg.seed3;
    endcase
  end

  always_comb begin
    if (cfg.count == '0) cnt = CountW'(1);
    else if (cfg.count > CountW'(BucketDepth)) cnt = CountW'(BucketDepth);
    else cnt = cfg.count;
  end

  // Restoring remainder, one bit per cycle, MSB first.
  logic [32:0] rem_sh;
  assign rem_sh = {rem, h[bitn[4:0]]};

  logic [31:0] kr, hm, hx, hf;
  assign kr = {k[16:0], k[31:17]};
  assign hx = seed_sel ^ (kr * 32'h1b873593);
  assign hm = {hx[18:0], hx[31:19]} * 32'd5 + 32'he6546b64;
  assign hf = (h ^ (h >> 13)) * 32'hc2b2ae35;

  assign in_stall = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  always_comb begin
    out_item.key   = key_r;
    out_item.stamp = stamp_r;
    out_item.slot1 = slot_q[0];
    out_item.slot2 = slot_q[1];
    out_item.slot3 = slot_q[2];
    out_item.lvl1  = lvl[0];
    out_item.lvl2  = lvl[1];
    out_item.lvl3  = lvl[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lane  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_r   <= key;
            stamp_r <= stamp;
            lvl[0]  <= level_of(r1);
            lvl[1]  <= level_of(r2);
            lvl[2]  <= level_of(r3);
            k       <= key * 32'hcc9e2d51;
            lane    <= '0;
            state   <= S_MIX;
          end
        end
        S_MIX: begin
          h     <= hm ^ 32'd4;
          state <= S_FIN1;
        end
        S_FIN1: begin
          h     <= (h ^ (h >> 16)) * 32'h85ebca6b;
          state <= S_FIN2;
        end
        S_FIN2: begin
          h     <= hf ^ (hf >> 16);
          state <= S_MOD;
          rem   <= '0;
          bitn  <= 6'd31;
        end
        S_MOD: begin
          if (rem_sh >= {20'd0, cnt}) rem <= 32'(rem_sh - {20'd0, cnt});
          else rem <= rem_sh[31:0];
          if (bitn == '0) begin
            if (rem_sh >= {20'd0, cnt}) slot_q[lane] <= SlotW'(rem_sh - {20'd0, cnt});
            else slot_q[lane] <= SlotW'(rem_sh);
            if (lane != 2'd2) begin
              lane  <= lane + 2'd1;
              state <= S_MIX;
            end else begin
              state <= S_DONE;
            end
          end else begin
            bitn <= bitn - 6'd1;
          end
        end
        S_DONE: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("front result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("front accepted while holding");
  a_lane: assert property (@(posedge clk) disable iff (rst)
    lane != 2'd3) else $error("bad lane");
`endif

endmodule

// ===== hdl/wtslf_queue.sv =====
// Two-entry queue between the front end and the table back end.
// Depends on wtslf_pkg.
module wtslf_queue import wtslf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  work_t wr_item,
  output logic  rd_valid,
  input  logic  rd_stall,
  output work_t rd_item
);

  work_t      mem [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic       push, pop;

  assign wr_stall = (fill == 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_item  = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop  = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_item;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_fill: assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfill");
  a_count: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> fill == $past(fill) + 2'd1) else $error("queue count");
  a_ptr: assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> wp == rp) else $error("queue pointers");
`endif

endmodule

// ===== hdl/wtslf_back.sv =====
// Back end: clearing pass, then read-modify-write of the three bucket tables
// and the match result in an output register. Depends on wtslf_pkg.
module wtslf_back import wtslf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  work_t       in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_key,
  output logic        out_hit
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

  state_t            state;
  logic [EntryW-1:0] tab1 [BucketDepth];
  logic [EntryW-1:0] tab2 [BucketDepth];
  logic [EntryW-1:0] tab3 [BucketDepth];
  logic [EntryW-1:0] rd1, rd2, rd3;
  logic [SlotW-1:0]  clr;
  work_t             cur;

  function automatic logic [LevelW:0] upd(input logic [EntryW-1:0] e,
      input logic [LevelW-1:0] fresh, input logic [StampW-1:0] now,
      input logic [LevelW-1:0] cap, input logic [7:0] gap);
    logic [StampW:0]   sum;
    logic [LevelW-1:0] capped;
    logic              wr;
    sum = {1'b0, e[EntryW-1:LevelW]} + (StampW+1)'(gap);
    capped = (fresh < cap) ? fresh : cap;
    wr = (sum == {1'b0, now}) || (fresh > e[LevelW-1:0]);
    return wr ? {1'b1, capped} : {1'b0, e[LevelW-1:0]};
  endfunction

  logic [LevelW:0] u1, u2, u3;
  assign u1 = upd(rd1, cur.lvl1, cur.stamp, cfg.cap, cfg.gap);
  assign u2 = upd(rd2, cur.lvl2, cur.stamp, cfg.cap, cfg.gap);
  assign u3 = upd(rd3, cur.lvl3, cur.stamp, cfg.cap, cfg.gap);

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    unique case (state)
      S_CLEAR: begin
        tab1[clr] <= '0;
        tab2[clr] <= '0;
        tab3[clr] <= '0;
      end
      S_WRITE: begin
        if (u1[LevelW]) tab1[cur.slot1] <= {cur.stamp, u1[LevelW-1:0]};
        if (u2[LevelW]) tab2[cur.slot2] <= {cur.stamp, u2[LevelW-1:0]};
        if (u3[LevelW]) tab3[cur.slot3] <= {cur.stamp, u3[LevelW-1:0]};
      end
      default: ;
    endcase
    if (state == S_READ) begin
      rd1 <= tab1[cur.slot1];
      rd2 <= tab2[cur.slot2];
      rd3 <= tab3[cur.slot3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == SlotW'(BucketDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cur <= in_item;
            state <= S_READ;
          end
        end
        S_READ: state <= S_WRITE;
        S_WRITE: begin
          out_valid <= 1'b1;
          out_hit <= (u1[LevelW-1:0] == cfg.cap) && (u2[LevelW-1:0] == cfg.cap) &&
                     (u3[LevelW-1:0] == cfg.cap);
          out_key <= ((u1[LevelW-1:0] == cfg.cap) && (u2[LevelW-1:0] == cfg.cap) &&
                      (u3[LevelW-1:0] == cfg.cap)) ? cur.key : '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_key: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_key == '0) else $error("key without match");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !out_valid) else $error("result during clear");
  a_write: assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |=> out_valid) else $error("result not posted");
`endif

endmodule

// ===== hdl/windowed_three_stage_level_filter_top.sv =====
// Windowed three-stage level filter, top level.
// The front end hashes and reduces one stage at a time (32-bit remainder) and
// takes no new item until the hash unit has passed on the last one.
// Reset: synchronous; registers return to defaults and a clearing pass empties the
// tables; the front end takes up to three transactions, then stalls until done.
module windowed_three_stage_level_filter_top import wtslf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       item_key,
  input  logic [StampW-1:0] time_index,
  input  logic [31:0]       random_one,
  input  logic [31:0]       random_two,
  input  logic [31:0]       random_three,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       reported_key,
  output logic              all_at_cap
);

  cfg_t  cfg;
  logic  fq_valid, fq_stall, qb_valid, qb_stall;
  work_t fq_item, qb_item;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign idx = reg_idx_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count <= CountW'(4096);
      cfg.cap   <= LevelW'(8);
      cfg.gap   <= 8'd3;
      cfg.seed1 <= 32'd1;
      cfg.seed2 <= 32'd2;
      cfg.seed3 <= 32'd2;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      unique case (paddr[AddrW-1:2])
        3'(REG_BUCKET_COUNT): cfg.count <= pwdata[CountW-1:0];
        3'(REG_CAP_LEVEL):    cfg.cap   <= pwdata[LevelW-1:0];
        3'(REG_EXPIRE_GAP):   cfg.gap   <= pwdata[7:0];
        3'(REG_SEED_ONE):     cfg.seed1 <= pwdata;
        3'(REG_SEED_TWO):     cfg.seed2 <= pwdata;
        3'(REG_SEED_THREE):   cfg.seed3 <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_BUCKET_COUNT: prdata = 32'(cfg.count);
      REG_CAP_LEVEL:    prdata = 32'(cfg.cap);
      REG_EXPIRE_GAP:   prdata = 32'(cfg.gap);
      REG_SEED_ONE:     prdata = cfg.seed1;
      REG_SEED_TWO:     prdata = cfg.seed2;
      REG_SEED_THREE:   prdata = cfg.seed3;
      default:          prdata = '0;
    endcase
  end

  wtslf_front u_front (
    .clk, .rst, .cfg,
    .in_valid, .in_stall,
    .key(item_key), .stamp(time_index),
    .r1(random_one), .r2(random_two), .r3(random_three),
    .out_valid(fq_valid), .out_stall(fq_stall), .out_item(fq_item)
  );

  wtslf_queue u_queue (
    .clk, .rst,
    .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_item(fq_item),
    .rd_valid(qb_valid), .rd_stall(qb_stall), .rd_item(qb_item)
  );

  wtslf_back u_back (
    .clk, .rst, .cfg,
    .in_valid(qb_valid), .in_stall(qb_stall), .in_item(qb_item),
    .out_valid, .out_stall,
    .out_key(reported_key), .out_hit(all_at_cap)
  );

endmodule
